// ===== hw/rtl/cfr_pkg.sv =====
// Shared types, codes and constants of the clock frame replacement core.
`default_nettype none
package cfr_pkg;

	localparam int FRAMES_DEFAULT = 64;
	localparam int SLOT_W = 6;
	localparam int OP_W = 3;
	localparam int ST_W = 2;

	// operation codes of an input item
	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_FREE   = 3'd1,
		OP_TOUCH  = 3'd2,
		OP_PIN    = 3'd3,
		OP_EVICT  = 3'd4
	} op_t;

	// result status codes
	typedef enum logic [ST_W-1:0] {
		ST_OK   = 2'd0,
		ST_NONE = 2'd1,
		ST_BAD  = 2'd2
	} st_t;

	// one slot entry in the mark RAM
	typedef struct packed {
		logic resident;
		logic accessed;
		logic pinned;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// controller states
	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_OP,
		S_SWEEP
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic eval;
		logic sweep;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic clear_last;
		logic empty;
		logic sweep_done;
	} stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cfr_ram.sv =====
// Generic single write, single read RAM with registered read data.
`default_nettype none
module cfr_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/cfr_ctrl.sv =====
// Controller state machine: clearing pass, command decode and sweep sequencing.
`default_nettype none
module cfr_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [cfr_pkg::OP_W-1:0]   opcode,
	input  wire cfr_pkg::stat_t             stat,
	output cfr_pkg::cmd_t                   cmd,
	output logic                            busy
);

	cfr_pkg::state_t state_q;
	cfr_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfr_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			cfr_pkg::S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) begin
					state_d = cfr_pkg::S_IDLE;
				end
			end
			cfr_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					if (cfr_pkg::op_t'(opcode) == cfr_pkg::OP_EVICT && !stat.empty) begin
						state_d = cfr_pkg::S_SWEEP;
					end else begin
						state_d = cfr_pkg::S_OP;
					end
				end
			end
			cfr_pkg::S_OP: begin
				cmd.eval = 1'b1;
				state_d = cfr_pkg::S_IDLE;
			end
			cfr_pkg::S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_done) begin
					state_d = cfr_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = cfr_pkg::S_CLEAR;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/cfr_dp.sv =====
// Datapath: mark RAM, clock hand, resident count, sweep position and result registers.
`default_nettype none
module cfr_dp #(
	parameter int FRAMES = cfr_pkg::FRAMES_DEFAULT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cfr_pkg::cmd_t                cmd,
	output cfr_pkg::stat_t                    stat,
	input  wire logic [cfr_pkg::OP_W-1:0]     opcode,
	input  wire logic [cfr_pkg::SLOT_W-1:0]   slot,
	input  wire logic                         pin_value,
	output logic      [cfr_pkg::SLOT_W-1:0]   victim_slot,
	output logic                              victim_found,
	output logic      [cfr_pkg::ST_W-1:0]     status,
	output logic                              done
);

	localparam int SW = $clog2(FRAMES);
	localparam int CW = ((SW > cfr_pkg::SLOT_W) ? SW : cfr_pkg::SLOT_W) + 1;
	localparam int NW = $clog2(FRAMES + 1);
	localparam int VW = $clog2(2 * FRAMES);

	// control state
	logic [SW-1:0]  hand_q;
	logic           hand_unset_q;
	logic [NW-1:0]  count_q;
	logic [SW-1:0]  clr_q;
	logic           done_q;

	// item and sweep registers
	cfr_pkg::op_t   op_q;
	logic [SW-1:0]  slot_q;
	logic           in_range_q;
	logic           pv_q;
	logic [SW-1:0]  pos_q;
	logic [VW-1:0]  visit_q;

	// result registers
	logic [cfr_pkg::SLOT_W-1:0] victim_slot_q;
	logic                       victim_found_q;
	cfr_pkg::st_t               status_q;

	// RAM ports
	logic                    we;
	logic [SW-1:0]           waddr;
	cfr_pkg::entry_t         wdata;
	logic [SW-1:0]           raddr;
	cfr_pkg::entry_t         e;
	logic [cfr_pkg::ENTRY_W-1:0] rdata_raw;

	// next values
	logic [SW-1:0]  hand_d;
	logic           hand_unset_d;
	logic [NW-1:0]  count_d;
	logic           res_load;
	logic [cfr_pkg::SLOT_W-1:0] res_victim;
	logic           res_found;
	cfr_pkg::st_t   res_status;
	logic           sweep_done;

	logic [CW-1:0]  slot_ext;
	logic [CW-1:0]  pos_ext;
	logic           in_range;
	logic [SW-1:0]  slot_addr;
	logic [SW-1:0]  start_pos;
	logic [SW-1:0]  pos_next;
	logic           last_visit;
	logic           is_evict;

	cfr_ram #(
		.WIDTH (cfr_pkg::ENTRY_W),
		.DEPTH (FRAMES)
	) u_marks (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_raw)
	);

	assign e = cfr_pkg::entry_t'(rdata_raw);

	// decode the slot field against the table size
	assign slot_ext   = CW'(slot);
	assign in_range   = slot_ext < CW'(FRAMES);
	assign slot_addr  = slot_ext[SW-1:0];
	assign is_evict   = cfr_pkg::op_t'(opcode) == cfr_pkg::OP_EVICT;
	assign start_pos  = hand_unset_q ? '0 : hand_q;
	assign pos_next   = (pos_q == SW'(FRAMES - 1)) ? '0 : pos_q + SW'(1);
	assign pos_ext    = CW'(pos_q);
	assign last_visit = visit_q == VW'(2 * FRAMES - 1);

	assign stat.clear_last = clr_q == SW'(FRAMES - 1);
	assign stat.empty      = count_q == '0;
	assign stat.sweep_done = sweep_done;

	// operation logic: RAM access, hand and count updates, result
	always_comb begin
		we = 1'b0;
		waddr = slot_q;
		wdata = '0;
		raddr = slot_addr;
		hand_d = hand_q;
		hand_unset_d = hand_unset_q;
		count_d = count_q;
		res_load = 1'b0;
		res_victim = '0;
		res_found = 1'b0;
		res_status = cfr_pkg::ST_OK;
		sweep_done = 1'b0;

		if (cmd.clear) begin
			we = 1'b1;
			waddr = clr_q;
		end

		// start the RAM read for the new item; set the hand for a sweep
		if (cmd.accept) begin
			raddr = is_evict ? start_pos : slot_addr;
			if (is_evict && count_q != '0) begin
				hand_d = start_pos;
				hand_unset_d = 1'b0;
			end
		end

		// single-slot operations, evict on an empty table and unused opcodes
		if (cmd.eval) begin
			res_load = 1'b1;
			case (op_q)
				cfr_pkg::OP_INSERT: begin
					if (!in_range_q || e.resident) begin
						res_status = cfr_pkg::ST_BAD;
					end else begin
						we = 1'b1;
						wdata.resident = 1'b1;
						count_d = count_q + NW'(1);
					end
				end
				cfr_pkg::OP_FREE: begin
					if (!in_range_q || !e.resident) begin
						res_status = cfr_pkg::ST_BAD;
					end else begin
						we = 1'b1;
						count_d = count_q - NW'(1);
						if (!hand_unset_q && hand_q == slot_q) begin
							hand_d = '0;
							hand_unset_d = 1'b1;
						end
					end
				end
				cfr_pkg::OP_TOUCH: begin
					if (!in_range_q || !e.resident) begin
						res_status = cfr_pkg::ST_BAD;
					end else begin
						we = 1'b1;
						wdata = e;
						wdata.accessed = 1'b1;
					end
				end
				cfr_pkg::OP_PIN: begin
					if (!in_range_q || !e.resident) begin
						res_status = cfr_pkg::ST_BAD;
					end else begin
						we = 1'b1;
						wdata = e;
						wdata.pinned = pv_q;
					end
				end
				cfr_pkg::OP_EVICT: begin
					res_status = cfr_pkg::ST_NONE;
				end
				default: begin
					res_status = cfr_pkg::ST_BAD;
				end
			endcase
		end

		// one slot visit per cycle; read of the next slot overlaps
		if (cmd.sweep) begin
			raddr = pos_next;
			waddr = pos_q;
			if (e.resident && e.accessed) begin
				we = 1'b1;
				wdata = e;
				wdata.accessed = 1'b0;
			end else if (e.resident && !e.pinned) begin
				we = 1'b1;
				res_load = 1'b1;
				res_victim = pos_ext[cfr_pkg::SLOT_W-1:0];
				res_found = 1'b1;
				hand_d = pos_next;
				count_d = count_q - NW'(1);
				sweep_done = 1'b1;
			end
			if (!sweep_done && last_visit) begin
				res_load = 1'b1;
				res_status = cfr_pkg::ST_NONE;
				sweep_done = 1'b1;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hand_q <= '0;
			hand_unset_q <= 1'b1;
			count_q <= '0;
			clr_q <= '0;
			done_q <= 1'b0;
		end else begin
			hand_q <= hand_d;
			hand_unset_q <= hand_unset_d;
			count_q <= count_d;
			done_q <= res_load;
			if (cmd.clear) begin
				clr_q <= clr_q + SW'(1);
			end
		end
	end

	// item, sweep and result registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= cfr_pkg::op_t'(opcode);
			slot_q <= slot_addr;
			in_range_q <= in_range;
			pv_q <= pin_value;
			pos_q <= start_pos;
			visit_q <= '0;
		end else if (cmd.sweep) begin
			pos_q <= pos_next;
			visit_q <= visit_q + VW'(1);
		end
		if (res_load) begin
			victim_slot_q <= res_victim;
			victim_found_q <= res_found;
			status_q <= res_status;
		end
	end

	assign victim_slot  = victim_slot_q;
	assign victim_found = victim_found_q;
	assign status       = status_q;
	assign done         = done_q;

endmodule
`default_nettype wire

// ===== hw/rtl/clock_frame_replacement_core.sv =====
// Top level of the second-chance clock frame replacement core.
//
//  Channel   Ports                               Handshake
//  command   opcode, slot, pin_value             taken when start && !busy
//  result    victim_slot, victim_found, status   shown for one cycle with done
//
// Insert, free, touch and pin read the slot entry from the mark RAM, then
// write it back; done rises in the cycle after that. Evict sweeps the slots
// in turn, up to 2*FRAMES visits; an empty table answers as a single-slot
// command does. After reset a clearing pass writes every RAM entry with busy
// high. The result has no back pressure: it stands for exactly one cycle.
`default_nettype none
module clock_frame_replacement_core #(
	parameter int FRAMES = cfr_pkg::FRAMES_DEFAULT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [cfr_pkg::OP_W-1:0]     opcode,
	input  wire logic [cfr_pkg::SLOT_W-1:0]   slot,
	input  wire logic                         pin_value,
	output logic                              done,
	output logic      [cfr_pkg::SLOT_W-1:0]   victim_slot,
	output logic                              victim_found,
	output logic      [cfr_pkg::ST_W-1:0]     status
);

	cfr_pkg::cmd_t  cmd;
	cfr_pkg::stat_t stat;

	cfr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	cfr_dp #(
		.FRAMES (FRAMES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.opcode       (opcode),
		.slot         (slot),
		.pin_value    (pin_value),
		.victim_slot  (victim_slot),
		.victim_found (victim_found),
		.status       (status),
		.done         (done)
	);

`ifndef SYNTH
	// an accepted item always keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// a result follows only from a cycle of work
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	// a reported victim always comes with an ok status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && victim_found |-> status == cfr_pkg::ST_OK)
		else $error("victim reported with failing status");

	// a failing result carries no victim
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != cfr_pkg::ST_OK |-> !victim_found && victim_slot == '0)
		else $error("failing result carries victim data");
`endif

endmodule
`default_nettype wire

// ===== bench/clock_frame_replacement_core_tb.sv =====
// Self-checking bench for the clock frame replacement core: directed, random and full-table command items.
`timescale 1ns / 1ps
module clock_frame_replacement_core_tb;
	import cfr_pkg::*;

	localparam int FRAMES = FRAMES_DEFAULT;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 2 * FRAMES + 16;
	localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_UNUSED_LAST = 3'd7;

	// one result item as the core reports it
	typedef struct {
		logic [SLOT_W-1:0] victim_slot;
		logic              victim_found;
		st_t               status;
	} frame_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [OP_W-1:0]   opcode = '0;
	logic [SLOT_W-1:0] slot = '0;
	logic              pin_value = 1'b0;
	logic              busy;
	logic              done;
	logic [SLOT_W-1:0] victim_slot;
	logic              victim_found;
	logic [ST_W-1:0]   status;

	// shadow copy of the frame table
	bit [FRAMES-1:0] frame_resident;
	bit [FRAMES-1:0] frame_accessed;
	bit [FRAMES-1:0] frame_pinned;
	int              shadow_hand;
	bit              hand_unset;

	frame_result_t expected_victims[$];
	int            mismatch_count = 0;
	bit            back_to_back = 1'b0;

	clock_frame_replacement_core #(.FRAMES(FRAMES)) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.slot        (slot),
		.pin_value   (pin_value),
		.done        (done),
		.victim_slot (victim_slot),
		.victim_found(victim_found),
		.status      (status)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// apply one command to the shadow table and return the result it must give
	function automatic frame_result_t apply_frame_op(logic [OP_W-1:0] op,
			logic [SLOT_W-1:0] s, logic pv);
		frame_result_t res;
		int pos;
		bit found;
		res.victim_slot = '0;
		res.victim_found = 1'b0;
		res.status = ST_OK;
		found = 1'b0;
		case (op)
			OP_INSERT: begin
				if (s >= FRAMES || frame_resident[s]) begin
					res.status = ST_BAD;
				end else begin
					frame_resident[s] = 1'b1;
					frame_accessed[s] = 1'b0;
					frame_pinned[s] = 1'b0;
				end
			end
			OP_FREE: begin
				if (s >= FRAMES || !frame_resident[s]) begin
					res.status = ST_BAD;
				end else begin
					frame_resident[s] = 1'b0;
					frame_accessed[s] = 1'b0;
					frame_pinned[s] = 1'b0;
					if (!hand_unset && shadow_hand == int'(s)) begin
						shadow_hand = 0;
						hand_unset = 1'b1;
					end
				end
			end
			OP_TOUCH: begin
				if (s >= FRAMES || !frame_resident[s])
					res.status = ST_BAD;
				else
					frame_accessed[s] = 1'b1;
			end
			OP_PIN: begin
				if (s >= FRAMES || !frame_resident[s])
					res.status = ST_BAD;
				else
					frame_pinned[s] = pv;
			end
			OP_EVICT: begin
				if (frame_resident == '0) begin
					res.status = ST_NONE;
				end else begin
					if (hand_unset) begin
						shadow_hand = 0;
						hand_unset = 1'b0;
					end
					pos = shadow_hand % FRAMES;
					// sweep at most two full turns of the clock
					for (int n = 0; n < 2 * FRAMES && !found; n++) begin
						if (frame_resident[pos]) begin
							if (frame_accessed[pos]) begin
								frame_accessed[pos] = 1'b0;
							end else if (!frame_pinned[pos]) begin
								frame_resident[pos] = 1'b0;
								frame_pinned[pos] = 1'b0;
								res.victim_slot = pos[SLOT_W-1:0];
								res.victim_found = 1'b1;
								shadow_hand = (pos + 1) % FRAMES;
								found = 1'b1;
							end
						end
						if (!found)
							pos = (pos + 1) % FRAMES;
					end
					if (!found)
						res.status = ST_NONE;
				end
			end
			default: begin
				res.status = ST_BAD;
			end
		endcase
		return res;
	endfunction

	// pick a random slot that is (or is not) resident; any slot when none fits
	function automatic logic [SLOT_W-1:0] pick_slot(bit want_resident);
		logic [SLOT_W-1:0] matches_q[$];
		for (int i = 0; i < FRAMES; i++) begin
			if (frame_resident[i] == want_resident)
				matches_q.push_back(i[SLOT_W-1:0]);
		end
		if (matches_q.size() == 0)
			return SLOT_W'($urandom_range(0, FRAMES - 1));
		return matches_q[$urandom_range(0, matches_q.size() - 1)];
	endfunction

	// send one command item and record what it must produce
	task automatic issue_command(logic [OP_W-1:0] op, logic [SLOT_W-1:0] s, logic pv);
		int unsigned gap;
		gap = back_to_back ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		slot <= s;
		pin_value <= pv;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		expected_victims.push_back(apply_frame_op(op, s, pv));
	endtask

	// directed: empty table, bad slots, second chance, all pinned, hand reset
	task automatic test_directed_cases();
		issue_command(OP_EVICT, 6'd0, 1'b0);
		issue_command(OP_FREE, 6'd0, 1'b0);
		issue_command(OP_TOUCH, 6'd63, 1'b0);
		issue_command(OP_PIN, 6'd63, 1'b1);
		issue_command(OP_INSERT, 6'd0, 1'b0);
		issue_command(OP_INSERT, 6'd0, 1'b1);
		issue_command(OP_INSERT, 6'd63, 1'b0);
		issue_command(OP_TOUCH, 6'd0, 1'b0);
		issue_command(OP_EVICT, 6'd63, 1'b1);
		issue_command(OP_PIN, 6'd0, 1'b1);
		issue_command(OP_EVICT, 6'd0, 1'b0);
		issue_command(OP_PIN, 6'd0, 1'b0);
		issue_command(OP_EVICT, 6'd0, 1'b0);
		issue_command(OP_INSERT, 6'd5, 1'b0);
		issue_command(OP_INSERT, 6'd6, 1'b0);
		issue_command(OP_EVICT, 6'd0, 1'b0);
		// free the slot under the hand
		issue_command(OP_FREE, 6'd6, 1'b0);
		issue_command(OP_INSERT, 6'd2, 1'b0);
		issue_command(OP_INSERT, 6'd42, 1'b0);
		issue_command(OP_TOUCH, 6'd42, 1'b0);
		issue_command(OP_PIN, 6'd42, 1'b1);
		issue_command(OP_EVICT, 6'd0, 1'b0);
		issue_command(OP_EVICT, 6'd21, 1'b1);
		issue_command(OP_FREE, 6'd42, 1'b0);
		for (int u = OP_UNUSED_FIRST; u <= OP_UNUSED_LAST; u++)
			issue_command(u[OP_W-1:0], 6'd63, 1'b1);
	endtask

	// random: mostly well-formed commands on live slots, some noise
	task automatic test_random_traffic(int count);
		int unsigned roll;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				back_to_back = ($urandom_range(0, 3) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 25)
				issue_command(OP_INSERT, pick_slot(1'b0), 1'($urandom));
			else if (roll < 40)
				issue_command(OP_TOUCH, pick_slot(1'b1), 1'($urandom));
			else if (roll < 52)
				issue_command(OP_PIN, pick_slot(1'b1), 1'($urandom));
			else if (roll < 62)
				issue_command(OP_FREE, pick_slot(1'b1), 1'($urandom));
			else if (roll < 85)
				issue_command(OP_EVICT, SLOT_W'($urandom), 1'($urandom));
			else
				issue_command(OP_W'($urandom_range(0, 7)), SLOT_W'($urandom),
					1'($urandom));
		end
		back_to_back = 1'b0;
	endtask

	// full table: fill every slot, mark some, then evict until only pinned slots are left
	task automatic test_full_table();
		for (int i = 0; i < FRAMES; i++)
			issue_command(OP_INSERT, pick_slot(1'b0), 1'b0);
		for (int i = 0; i < FRAMES / 2; i++)
			issue_command(OP_TOUCH, pick_slot(1'b1), 1'b0);
		for (int i = 0; i < FRAMES / 4; i++)
			issue_command(OP_PIN, pick_slot(1'b1), 1'b1);
		back_to_back = 1'b1;
		for (int i = 0; i < FRAMES + 6; i++)
			issue_command(OP_EVICT, SLOT_W'($urandom), 1'b0);
		back_to_back = 1'b0;
		// drop the pinned leftovers, then evict the empty table
		while (frame_resident != '0)
			issue_command(OP_FREE, pick_slot(1'b1), 1'b0);
		issue_command(OP_EVICT, 6'd63, 1'b1);
	endtask

	// check each result item against the oldest expectation
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (expected_victims.size() == 0) begin
				$display("%0t: unexpected result, actual slot %0d found %0b status %0d",
					$time, victim_slot, victim_found, status);
				mismatch_count++;
			end else begin
				want = expected_victims.pop_front();
				if (victim_slot !== want.victim_slot) begin
					$display("%0t: victim_slot mismatch, expected %0d, actual %0d",
						$time, want.victim_slot, victim_slot);
					mismatch_count++;
				end
				if (victim_found !== want.victim_found) begin
					$display("%0t: victim_found mismatch, expected %0b, actual %0b",
						$time, want.victim_found, victim_found);
					mismatch_count++;
				end
				if (status !== want.status) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, want.status, status);
					mismatch_count++;
				end
			end
		end
	end

	// end the run when nothing is accepted for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		frame_resident = '0;
		frame_accessed = '0;
		frame_pinned = '0;
		shadow_hand = 0;
		hand_unset = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_traffic(300);
		test_full_table();
		start <= 1'b0;

		// drain outstanding results, then hold for one worst-case evict
		while (expected_victims.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== clock_frame_replacement_core.f =====
hw/rtl/cfr_pkg.sv
hw/rtl/cfr_ram.sv
hw/rtl/cfr_ctrl.sv
hw/rtl/cfr_dp.sv
hw/rtl/clock_frame_replacement_core.sv
bench/clock_frame_replacement_core_tb.sv
